// ----- sv/cwcs_pkg.sv -----
`default_nettype none
package cwcs_pkg;

  localparam int MaxResults = 5;
  localparam int CountW     = $clog2(MaxResults + 1);
  localparam int IndexW     = $clog2(MaxResults);

  // Character codes used by the stripper.
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNul       = 8'h00;

  // Literal and comment modes.
  localparam logic [1:0] LitNone   = 2'd0;
  localparam logic [1:0] LitString = 2'd1;
  localparam logic [1:0] LitChar   = 2'd2;
  localparam logic [1:0] CmtNone   = 2'd0;
  localparam logic [1:0] CmtLine   = 2'd1;
  localparam logic [1:0] CmtBlock  = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] literal_mode;
    logic [1:0] comment_mode;
    logic       star_seen;
    logic [7:0] prev_raw;
    logic [7:0] prev_prev_raw;
    logic [7:0] last_emitted;
    logic       emitted_since_directive;
    logic       pending_space;
    logic       pending_slash;
    logic       in_directive;
  } strip_state_t;

  // Bytes produced by one input transaction, first byte in entry 0.
  typedef struct packed {
    logic [CountW-1:0]             count;
    logic [MaxResults-1:0][7:0]    chars;
  } emit_list_t;

  localparam strip_state_t StateReset = '{
    literal_mode:            LitNone,
    comment_mode:            CmtNone,
    star_seen:               1'b0,
    prev_raw:                ChNewline,
    prev_prev_raw:           ChNul,
    last_emitted:            ChNul,
    emitted_since_directive: 1'b0,
    pending_space:           1'b0,
    pending_slash:           1'b0,
    in_directive:            1'b0
  };

  function automatic logic is_punct(input logic [7:0] c);
    logic r;
    case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3B, 8'h25, 8'h3C, 8'h3E, 8'h3F,
      8'h21, 8'h7E, 8'h5E, 8'h26, 8'h28, 8'h29, 8'h2C, 8'h7B, 8'h7D,
      8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cwcs_step.sv -----
`default_nettype none
module cwcs_step
  import cwcs_pkg::*;
(
  input  strip_state_t cur,
  input  in_item_t     item,
  output strip_state_t nxt,
  output emit_list_t   emit
);

  always_comb begin
    strip_state_t          s;
    logic [7:0]            c;
    logic [IndexW:0]       n;
    logic [MaxResults-1:0][7:0] chars;
    logic                  do_code;
    logic                  closing;
    logic                  escaped;

    s       = cur;
    c       = item.in_char;
    n       = '0;
    chars   = '0;
    do_code = 1'b0;
    closing = ((cur.literal_mode == LitString) && (c == ChDquote)) ||
              ((cur.literal_mode == LitChar) && (c == ChSquote));
    escaped = (cur.prev_raw == ChBackslash) && (cur.prev_prev_raw != ChBackslash);

    if (cur.in_directive) begin
      if (c == ChNewline) begin
        chars[n[IndexW-1:0]] = ChNewline; n = n + 1'b1;
        s.last_emitted = ChNewline;
        s.in_directive = 1'b0;
        s.emitted_since_directive = 1'b0;
      end else if (!(c == ChSpace && s.last_emitted == ChSpace)) begin
        chars[n[IndexW-1:0]] = c; n = n + 1'b1;
        s.last_emitted = c; s.emitted_since_directive = 1'b1;
      end
    end else if (cur.comment_mode == CmtLine) begin
      if (c == ChNewline) begin
        s.comment_mode = CmtNone;
        do_code = 1'b1;
      end
    end else if (cur.comment_mode == CmtBlock) begin
      if (cur.star_seen && c == ChSlash) begin
        s.comment_mode = CmtNone;
        s.star_seen = 1'b0;
      end else begin
        s.star_seen = (c == ChStar);
      end
    end else if (cur.literal_mode != LitNone) begin
      if (closing && !escaped) s.literal_mode = LitNone;
      chars[n[IndexW-1:0]] = c; n = n + 1'b1;
      s.last_emitted = c; s.emitted_since_directive = 1'b1;
    end else if (cur.pending_slash) begin
      s.pending_slash = 1'b0;
      if (c == ChSlash) begin
        s.comment_mode = CmtLine;
      end else if (c == ChStar) begin
        s.comment_mode = CmtBlock;
        s.star_seen = 1'b0;
      end else begin
        chars[n[IndexW-1:0]] = ChSlash; n = n + 1'b1;
        s.last_emitted = ChSlash; s.emitted_since_directive = 1'b1;
        do_code = 1'b1;
      end
    end else begin
      do_code = 1'b1;
    end

    // Plain code byte with no slash pending.
    if (do_code) begin
      if (c == ChSpace || c == ChTab || c == ChNewline) begin
        if (s.emitted_since_directive && !is_punct(s.last_emitted) &&
            s.last_emitted != ChSpace) begin
          s.pending_space = 1'b1;
        end
      end else if (c == ChHash && cur.prev_raw == ChNewline) begin
        s.pending_space = 1'b0;
        if (s.emitted_since_directive) begin
          if (s.last_emitted != ChSemi) begin
            chars[n[IndexW-1:0]] = ChSemi; n = n + 1'b1;
          end
          chars[n[IndexW-1:0]] = ChNewline; n = n + 1'b1;
        end
        chars[n[IndexW-1:0]] = ChHash; n = n + 1'b1;
        s.last_emitted = ChHash; s.emitted_since_directive = 1'b1;
        s.in_directive = 1'b1;
      end else if (c == ChSlash) begin
        s.pending_space = 1'b0;
        s.pending_slash = 1'b1;
      end else begin
        if (s.pending_space) begin
          s.pending_space = 1'b0;
          if (!is_punct(c)) begin
            chars[n[IndexW-1:0]] = ChSpace; n = n + 1'b1;
          end
        end
        if (c == ChDquote) begin
          s.literal_mode = LitString;
        end else if (c == ChSquote) begin
          s.literal_mode = LitChar;
        end
        chars[n[IndexW-1:0]] = c; n = n + 1'b1;
        s.last_emitted = c; s.emitted_since_directive = 1'b1;
      end
    end

    s.prev_prev_raw = cur.prev_raw;
    s.prev_raw      = c;

    // Final byte of a stream: flush what is pending, then start over.
    if (item.in_last) begin
      if (s.pending_slash) begin
        chars[n[IndexW-1:0]] = ChSlash; n = n + 1'b1;
      end else if (s.pending_space) begin
        chars[n[IndexW-1:0]] = ChSpace; n = n + 1'b1;
      end
      if (s.in_directive) begin
        chars[n[IndexW-1:0]] = ChNewline; n = n + 1'b1;
      end
      s = StateReset;
    end

    nxt        = s;
    emit.count = CountW'(n);
    emit.chars = chars;
  end

endmodule
`default_nettype wire

// ----- sv/cwcs_emit_buf.sv -----
`default_nettype none
module cwcs_emit_buf
  import cwcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  emit_list_t list,
  output logic       busy,
  output logic       dst_valid,
  input  logic       dst_stall,
  output out_item_t  dst_data
);

  logic [7:0]        chars [MaxResults];
  logic [CountW-1:0] remain;
  logic [IndexW-1:0] ptr;
  logic              take;

  assign dst_valid         = (remain != '0);
  assign take              = dst_valid && !dst_stall;
  assign dst_data.out_char = chars[ptr];
  assign dst_data.run_last = (remain == CountW'(1));

  // The buffer can be reloaded once its last byte leaves in this cycle.
  assign busy = (remain > CountW'(1)) || ((remain == CountW'(1)) && dst_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      ptr    <= '0;
    end else if (load) begin
      remain <= list.count;
      ptr    <= '0;
    end else if (take) begin
      remain <= remain - 1'b1;
      ptr    <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        chars[i] <= list.chars[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/c_source_whitespace_comment_stripper.sv -----
`default_nettype none
// C source minifier. One raw source byte enters per transaction on the src
// channel and zero to four minified bytes leave, one per transaction, on the
// dst channel; run_last marks the final byte produced for each input byte.
// The stripper state is updated in the cycle a byte is accepted, and the
// bytes it produces are held in a five-entry result buffer that drains one
// byte per cycle while dst_stall is low, so the first of them is offered in
// the cycle after the input byte is taken. With dst_stall low, a byte that
// yields zero or one output bytes never holds src_stall, so most code streams
// through at one byte per clock. A byte that yields two or more bytes holds
// src_stall while the buffer drains, and so does any buffered byte that
// dst_stall holds back. Bytes that yield more than one are a directive start,
// a character that follows a slash which did not open a comment, a word
// character that follows a collapsed space, and a flush at the final byte.
// Setting in_last on a byte flushes a pending slash or space, closes an open
// directive line and returns the block to its reset state for the next
// stream. There is no configuration and no clearing pass after reset.
module c_source_whitespace_comment_stripper
  import cwcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_data,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_item_t dst_data
);

  strip_state_t state;
  strip_state_t state_next;
  emit_list_t   list;
  logic         busy;
  logic         accept;

  assign src_stall = busy;
  assign accept    = src_valid && !busy;

  // All per-byte decisions are made here from the current state.
  cwcs_step u_step (
    .cur  (state),
    .item (src_data),
    .nxt  (state_next),
    .emit (list)
  );

  // Stripper state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // The result buffer separates the two sides, so a new byte is taken in
  // the same cycle the previous result's last byte is delivered.
  cwcs_emit_buf u_emit_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .list      (list),
    .busy      (busy),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule
`default_nettype wire
